// File: hdl/awa_pkg.sv
// ----------------------------------------------------------------------------
// awa_pkg
// Shared types, widths and constants of the ADC window average block.
// ----------------------------------------------------------------------------
`default_nettype none

package awa_pkg;

    localparam int RING_DEPTH_DEF = 64;

    localparam int SAMPLE_W = 12;
    localparam int WORD_W   = 16;
    localparam int CNT_W    = 7;
    localparam int ERR_W    = 16;
    // largest sum: 127 samples of 4095 plus the rounding term
    localparam int SUM_W    = SAMPLE_W + CNT_W;
    localparam int STEP_W   = $clog2(SUM_W);

    localparam int ERR_BIT  = 15;

    typedef struct packed {
        logic                action;
        logic [WORD_W-1:0]   sample_word;
        logic [CNT_W-1:0]    window_count;
    } t_adc_in;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic [ERR_W-1:0]    error_count;
    } t_adc_out;

    typedef enum logic {
        ACT_PUSH  = 1'b0,
        ACT_QUERY = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// File: hdl/awa_div.sv
// ----------------------------------------------------------------------------
// awa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module awa_div (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire awa_pkg::t_div_req i_req,
    output awa_pkg::t_div_rsp o_rsp
);

    localparam int SUM_W  = awa_pkg::SUM_W;
    localparam int CNT_W  = awa_pkg::CNT_W;
    localparam int STEP_W = awa_pkg::STEP_W;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dvs;
    logic [SUM_W-1:0]  r_quo;

    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    diff;
    logic              fits;

    assign shifted = {r_rem, r_quo[SUM_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign fits    = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvs <= i_req.divisor;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits CNT_W bits
            r_rem <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

// File: hdl/adc_window_average_top.sv
// ----------------------------------------------------------------------------
// adc_window_average_top
// Ring of recent ADC samples with a rounded moving average on query.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------
//  in       | input     | i_in_valid / o_in_stall | i_in_data  (t_adc_in)
//  out      | output    | o_out_valid/ i_out_stall| o_out_data (t_adc_out)
//
//  After reset the ring is swept to zero, one entry a cycle, with the input
//  stalled.
//  A push writes its sample into the ring. A query sums the ring over its
//  single read port, runs the serial divider until its done flag, and loads
//  the output register: the input stays stalled while it does so, and the
//  result beat is valid from the cycle the input is ready again.
//  A result waiting on a stalled output holds the next query in its last step.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_window_average_top #(
    parameter int RING_DEPTH = awa_pkg::RING_DEPTH_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire awa_pkg::t_adc_in i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output awa_pkg::t_adc_out  o_out_data
);

    localparam int AW       = $clog2(RING_DEPTH);
    localparam int SAMPLE_W = awa_pkg::SAMPLE_W;
    localparam int CNT_W    = awa_pkg::CNT_W;
    localparam int ERR_W    = awa_pkg::ERR_W;
    localparam int SUM_W    = awa_pkg::SUM_W;
    localparam int DEPTH_W  = $clog2(RING_DEPTH + 1);
    localparam int CMP_W    = (DEPTH_W > CNT_W) ? DEPTH_W : CNT_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

    awa_pkg::t_state   r_state, n_state;

    logic [SAMPLE_W-1:0] r_ring [RING_DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;
    logic                r_rd_vld;

    logic [AW-1:0]       r_wr_idx;
    logic [AW-1:0]       r_pos;
    logic [AW-1:0]       pos_dec;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_left;
    logic [SUM_W-1:0]    r_sum;
    logic [ERR_W-1:0]    r_err;
    awa_pkg::t_adc_out   r_out;
    logic                r_out_vld;

    logic                in_acc;
    logic                is_push;
    logic                wr_en;
    logic [SAMPLE_W-1:0] wr_data;
    logic                rd_en;
    logic                sum_last;
    logic                out_free;
    logic                out_load;
    logic [CNT_W-1:0]    cnt_clamp;

    awa_pkg::t_div_req   div_req;
    awa_pkg::t_div_rsp   div_rsp;

    assign in_acc   = i_in_valid && (r_state == awa_pkg::ST_IDLE);
    assign is_push  = (i_in_data.action == awa_pkg::ACT_PUSH);
    assign pos_dec  = (r_pos == '0) ? LAST_IDX : r_pos - 1'b1;
    assign sum_last = (r_left == '0) && !r_rd_vld;
    assign out_free = !r_out_vld || !i_out_stall;

    // window of zero reads as one, anything past the ring as the whole ring
    always_comb begin
        if (i_in_data.window_count == '0) begin
            cnt_clamp = CNT_W'(1);
        end else if (CMP_W'(i_in_data.window_count) > CMP_W'(RING_DEPTH)) begin
            cnt_clamp = CNT_W'(RING_DEPTH);
        end else begin
            cnt_clamp = i_in_data.window_count;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            awa_pkg::ST_CLEAR: begin
                if (r_wr_idx == LAST_IDX) n_state = awa_pkg::ST_IDLE;
            end
            awa_pkg::ST_IDLE: begin
                if (in_acc && !is_push) n_state = awa_pkg::ST_SUM;
            end
            awa_pkg::ST_SUM: begin
                if (sum_last) n_state = awa_pkg::ST_DIV;
            end
            awa_pkg::ST_DIV: begin
                if (div_rsp.done) n_state = awa_pkg::ST_DONE;
            end
            awa_pkg::ST_DONE: begin
                if (out_free) n_state = awa_pkg::ST_IDLE;
            end
            default: n_state = awa_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        wr_en            = 1'b0;
        wr_data          = '0;
        rd_en            = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = r_sum + SUM_W'(r_cnt >> 1);
        div_req.divisor  = r_cnt;
        unique case (r_state)
            awa_pkg::ST_CLEAR: begin
                wr_en = 1'b1;
            end
            awa_pkg::ST_IDLE: begin
                wr_en   = in_acc && is_push;
                wr_data = i_in_data.sample_word[SAMPLE_W-1:0];
            end
            awa_pkg::ST_SUM: begin
                rd_en         = (r_left != '0);
                div_req.start = sum_last;
            end
            awa_pkg::ST_DIV: begin
            end
            awa_pkg::ST_DONE: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    // sample ring, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) r_ring[r_wr_idx] <= wr_data;
        if (rd_en) r_rd_data <= r_ring[pos_dec];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= awa_pkg::ST_CLEAR;
            r_wr_idx  <= '0;
            r_err     <= '0;
            r_rd_vld  <= 1'b0;
            r_left    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            // the clearing sweep wraps the write index back to zero
            if (wr_en) r_wr_idx <= (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + 1'b1;
            if (in_acc && is_push && i_in_data.sample_word[awa_pkg::ERR_BIT]
                    && (r_err != '1)) begin
                r_err <= r_err + 1'b1;
            end
            if (in_acc && !is_push) begin
                r_left <= cnt_clamp;
            end else if (rd_en) begin
                r_left <= r_left - 1'b1;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && !is_push) begin
            r_cnt <= cnt_clamp;
            r_pos <= r_wr_idx;
            r_sum <= '0;
        end else begin
            if (rd_en) r_pos <= pos_dec;
            if (r_rd_vld) r_sum <= r_sum + SUM_W'(r_rd_data);
        end
        if (out_load) begin
            r_out.average     <= div_rsp.quotient[SAMPLE_W-1:0];
            r_out.error_count <= r_err;
        end
    end

    awa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_in_stall  = (r_state != awa_pkg::ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
